// ----- rtl/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants of the contrast pixel counter
// Frame limits, field widths, register indexes and the line store bank types.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;

  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int COUNT_W    = 18;
  localparam int THR_W      = 8;
  localparam int FW_W       = 10;
  localparam int FH_W       = 9;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  // Line store is split into even and odd column banks
  localparam int BANK_DEPTH = MAX_WIDTH / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  typedef logic [PIX_W-1:0]   pixel_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [THR_W-1:0]   thr_t;
  typedef logic [FW_W-1:0]    fwidth_t;
  typedef logic [FH_W-1:0]    fheight_t;
  typedef logic [BANK_AW-1:0] bank_addr_t;

  localparam thr_t     THR_RESET = thr_t'(128);
  localparam fwidth_t  FW_RESET  = fwidth_t'(320);
  localparam fheight_t FH_RESET  = fheight_t'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_reg_t;

  // One write to a bank: pixel and flag fields have their own enables
  typedef struct packed {
    logic       en_pix;
    logic       en_flag;
    bank_addr_t addr;
    pixel_t     pix;
    logic       flag;
  } bank_wr_t;

  typedef struct packed {
    pixel_t pix;
    logic   flag;
  } bank_rd_t;

  // Absolute difference strictly above threshold
  function automatic logic contrasts(input pixel_t a, input pixel_t b, input thr_t thr);
    pixel_t diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff > thr;
  endfunction

endpackage

// ----- rtl/cpc_pixel_if.sv -----
// ----------------------------------------------------------------------------
// cpc_pixel_if: pixel input channel
// Valid/ready channel that carries one grey pixel per item.
// ----------------------------------------------------------------------------
interface cpc_pixel_if;
  import cpc_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);

endinterface

// ----- rtl/cpc_count_if.sv -----
// ----------------------------------------------------------------------------
// cpc_count_if: frame count output channel
// Valid/ready channel that carries the contrast count of one finished frame.
// ----------------------------------------------------------------------------
interface cpc_count_if;
  import cpc_pkg::*;

  logic   valid;
  logic   ready;
  count_t contrast_count;

  modport source (output valid, output contrast_count, input ready);
  modport sink   (input valid, input contrast_count, output ready);

endinterface

// ----- rtl/contrast_pixel_counter.sv -----
// ----------------------------------------------------------------------------
// contrast_pixel_counter: four-neighbor contrast pixel count per frame
// Throughput: one pixel per cycle unless stalled at a frame end, set by one
// read and one write-back of the banked line store per pixel. The frame count
// is registered as its last pixel leaves the compute stage. Reset (synchronous)
// clears the position, running count and pipeline and loads default sizes; the
// line store is not cleared and is always written before it is read.
// ----------------------------------------------------------------------------
module contrast_pixel_counter (
  input  logic                               clk,
  input  logic                               rst_n,
  cpc_pixel_if.sink                          in_if,
  cpc_count_if.source                        out_if,
  input  logic                               cfg_wr_en,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import cpc_pkg::*;

  // Configuration registers
  thr_t     threshold_r;
  fwidth_t  frame_width_r;
  fheight_t frame_height_r;

  // Position of the next pixel
  col_t column_index_r, column_index_nxt;
  row_t row_index_r, row_index_nxt;

  // Compute stage
  logic   b_valid_r;
  pixel_t b_pix_r;
  col_t   b_col_r;
  logic   b_has_above_r;
  logic   b_row_end_r;
  logic   b_last_row_r;

  // Forwarded line store data
  logic   fwd_pix_hit_r;
  pixel_t fwd_pix_r;
  logic   fwd_flag_hit_r;
  logic   fwd_flag_r;

  // Horizontal carry and frame count
  pixel_t left_pixel_r;
  logic   left_flag_r;
  count_t count_r, count_nxt;

  // Output register
  logic   out_valid_r;
  count_t out_count_r;

  col_t      last_col;
  row_t      last_row_idx;
  fwidth_t   fw_m1;
  fheight_t  fh_m1;
  logic      accept;
  logic      row_end_a;
  logic      last_row_a;
  logic      b_emit;
  logic      b_advance;
  logic      b_done;
  col_t      b_col_m1;
  pixel_t    above_pix;
  logic      above_flag;
  logic      d_left;
  logic      d_up;
  logic      left_fl;
  logic      cur;
  logic      inc_left;
  logic      inc_up;
  logic      inc_self;
  logic      hit_pix;
  logic      hit_flag_own;
  logic      hit_flag_left;
  bank_wr_t  bank_wr [2];
  bank_rd_t  bank_rd [2];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THR_RESET;
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold_r    <= cfg_wdata[THR_W-1:0];
        CFG_WIDTH:     frame_width_r  <= cfg_wdata[FW_W-1:0];
        CFG_HEIGHT:    frame_height_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes to 1..max and take the last column and row
  always_comb begin
    fw_m1 = frame_width_r - fwidth_t'(1);
    fh_m1 = frame_height_r - fheight_t'(1);
    if (frame_width_r == '0) begin
      last_col = '0;
    end else if (frame_width_r > fwidth_t'(MAX_WIDTH)) begin
      last_col = col_t'(MAX_WIDTH - 1);
    end else begin
      last_col = fw_m1[COL_W-1:0];
    end
    if (frame_height_r == '0) begin
      last_row_idx = '0;
    end else if (frame_height_r > fheight_t'(MAX_HEIGHT)) begin
      last_row_idx = row_t'(MAX_HEIGHT - 1);
    end else begin
      last_row_idx = fh_m1[ROW_W-1:0];
    end
  end

  // Handshake: the compute stage stalls only on a frame end with output full
  assign b_emit    = b_row_end_r && b_last_row_r;
  assign b_advance = !(b_emit && out_valid_r && !out_if.ready);
  assign b_done    = b_valid_r && b_advance;
  assign in_if.ready = !b_valid_r || b_advance;
  assign accept    = in_if.valid && in_if.ready;

  assign row_end_a  = column_index_r >= last_col;
  assign last_row_a = row_index_r >= last_row_idx;

  // Advance the raster position
  always_comb begin
    column_index_nxt = column_index_r;
    row_index_nxt    = row_index_r;
    if (accept) begin
      if (row_end_a) begin
        column_index_nxt = '0;
        row_index_nxt    = last_row_a ? '0 : row_index_r + row_t'(1);
      end else begin
        column_index_nxt = column_index_r + col_t'(1);
      end
    end
  end

  // Line store reads and the compute stage's data
  assign b_col_m1   = b_col_r - col_t'(1);
  assign above_pix  = fwd_pix_hit_r ? fwd_pix_r
                    : (b_col_r[0] ? bank_rd[1].pix : bank_rd[0].pix);
  assign above_flag = fwd_flag_hit_r ? fwd_flag_r
                    : (b_col_r[0] ? bank_rd[1].flag : bank_rd[0].flag);

  // Settle left neighbor's horizontal test and the upper pixel's vertical test
  always_comb begin
    d_left   = (b_col_r != '0) && contrasts(b_pix_r, left_pixel_r, threshold_r);
    left_fl  = left_flag_r || d_left;
    d_up     = b_has_above_r && contrasts(b_pix_r, above_pix, threshold_r);
    cur      = d_left || d_up;
    inc_left = (b_col_r != '0) && b_last_row_r && left_fl;
    inc_up   = b_has_above_r && (above_flag || d_up);
    inc_self = b_emit && cur;
    count_nxt = count_r + count_t'(inc_left) + count_t'(inc_up) + count_t'(inc_self);
  end

  // Bank write-back: pixel to its own column, flags to left and row-end columns
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      if (b_col_r[0] == e[0]) begin
        bank_wr[e].addr    = b_col_r[COL_W-1:1];
        bank_wr[e].en_pix  = b_done;
        bank_wr[e].en_flag = b_done && !b_last_row_r && b_row_end_r;
        bank_wr[e].flag    = cur;
      end else begin
        bank_wr[e].addr    = b_col_m1[COL_W-1:1];
        bank_wr[e].en_pix  = 1'b0;
        bank_wr[e].en_flag = b_done && !b_last_row_r && (b_col_r != '0);
        bank_wr[e].flag    = left_fl;
      end
      bank_wr[e].pix = b_pix_r;
    end
  end

  // Forward write-back data to a read of the same column in the same cycle
  always_comb begin
    hit_pix       = b_valid_r && (b_col_r == column_index_r);
    hit_flag_own  = b_valid_r && !b_last_row_r && b_row_end_r
                    && (b_col_r == column_index_r);
    hit_flag_left = b_valid_r && !b_last_row_r && (b_col_r != '0)
                    && (b_col_m1 == column_index_r);
  end

  cpc_bank_ram u_bank_even (
    .clk     (clk),
    .wr      (bank_wr[0]),
    .rd_en   (accept),
    .rd_addr (column_index_r[COL_W-1:1]),
    .rd      (bank_rd[0])
  );

  cpc_bank_ram u_bank_odd (
    .clk     (clk),
    .wr      (bank_wr[1]),
    .rd_en   (accept),
    .rd_addr (column_index_r[COL_W-1:1]),
    .rd      (bank_rd[1])
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_index_r <= '0;
      row_index_r    <= '0;
      b_valid_r      <= 1'b0;
      left_pixel_r   <= '0;
      left_flag_r    <= 1'b0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      column_index_r <= column_index_nxt;
      row_index_r    <= row_index_nxt;
      if (accept) begin
        b_valid_r <= 1'b1;
      end else if (b_done) begin
        b_valid_r <= 1'b0;
      end
      if (b_done) begin
        left_pixel_r <= b_row_end_r ? '0 : b_pix_r;
        left_flag_r  <= b_row_end_r ? 1'b0 : cur;
        count_r      <= b_emit ? '0 : count_nxt;
      end
      if (b_done && b_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of the compute stage and forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix_r        <= in_if.pixel_value;
      b_col_r        <= column_index_r;
      b_has_above_r  <= row_index_r != '0;
      b_row_end_r    <= row_end_a;
      b_last_row_r   <= last_row_a;
      fwd_pix_hit_r  <= hit_pix;
      fwd_pix_r      <= b_pix_r;
      fwd_flag_hit_r <= hit_flag_own || hit_flag_left;
      fwd_flag_r     <= hit_flag_own ? cur : left_fl;
    end
  end

  // Hold the frame count
  always_ff @(posedge clk) begin
    if (b_done && b_emit) begin
      out_count_r <= count_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.contrast_count = out_count_r;

endmodule

// ----- rtl/cpc_bank_ram.sv -----
// ----------------------------------------------------------------------------
// cpc_bank_ram: one bank of the line store
// Holds the pixel of the row above and its pending flag for half the columns.
// One write port with per-field enables, one registered read port.
// ----------------------------------------------------------------------------
module cpc_bank_ram (
  input  logic              clk,
  input  cpc_pkg::bank_wr_t wr,
  input  logic              rd_en,
  input  cpc_pkg::bank_addr_t rd_addr,
  output cpc_pkg::bank_rd_t rd
);
  import cpc_pkg::*;

  pixel_t pix_mem  [BANK_DEPTH];
  logic   flag_mem [BANK_DEPTH];

  // Write fields independently
  always_ff @(posedge clk) begin
    if (wr.en_pix) begin
      pix_mem[wr.addr] <= wr.pix;
    end
    if (wr.en_flag) begin
      flag_mem[wr.addr] <= wr.flag;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.pix  <= pix_mem[rd_addr];
      rd.flag <= flag_mem[rd_addr];
    end
  end

endmodule

// ----- tb/sv/tb_contrast_pixel_counter.sv -----
// ----------------------------------------------------------------------------
// tb_contrast_pixel_counter: self-checking bench of the contrast pixel counter
// Streams whole frames of grey pixels through the valid/ready channels, runs
// an in-bench frame predictor on every accepted pixel and compares each frame
// count with the oldest expected count. Sizes and threshold are changed only
// between frames, under varying sender and receiver idling and one long hold.
// ----------------------------------------------------------------------------
module tb_contrast_pixel_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import cpc_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 16;
  localparam int PHASE_ITEMS = 80;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {FILL_RANDOM, FILL_SMOOTH, FILL_EXTREME} fill_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cpc_pixel_if pix_ch ();
  cpc_count_if cnt_ch ();

  contrast_pixel_counter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (pix_ch),
    .out_if    (cnt_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Predictor copy of the registers and the frame state
  thr_t        mdl_threshold;
  fwidth_t     mdl_width;
  fheight_t    mdl_height;
  pixel_t      mdl_row_above [MAX_WIDTH];
  bit          mdl_pending [MAX_WIDTH];
  pixel_t      mdl_left_pix;
  bit          mdl_left_flag;
  int unsigned mdl_col;
  int unsigned mdl_row;
  int unsigned mdl_count;

  pixel_t pixel_queue [$];
  count_t exp_counts [$];
  int     pixels_queued;
  int     pixels_accepted;
  int     fail_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  logic   recv_hold;
  bit     hold_armed;
  logic   pix_fire;

  function automatic int unsigned active_width();
    if (mdl_width == 0) return 1;
    if (mdl_width > MAX_WIDTH) return MAX_WIDTH;
    return mdl_width;
  endfunction

  function automatic int unsigned active_height();
    if (mdl_height == 0) return 1;
    if (mdl_height > MAX_HEIGHT) return MAX_HEIGHT;
    return mdl_height;
  endfunction

  function automatic bit differs(input pixel_t a, input pixel_t b);
    int gap;
    gap = int'(a) - int'(b);
    if (gap < 0) gap = -gap;
    return gap > int'(mdl_threshold);
  endfunction

  // Advance the frame state by one pixel; queue the count on the frame's last pixel
  task automatic predict_pixel(input pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    bit last_row;
    bit row_end;
    bit cur;
    bit hit;
    bit flag;
    w = active_width();
    h = active_height();
    c = mdl_col;
    r = mdl_row;
    last_row = (r >= h - 1);
    row_end = (c >= w - 1);
    cur = 1'b0;
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    // close the horizontal tests of the left neighbor
    if (c > 0) begin
      hit = differs(px, mdl_left_pix);
      flag = mdl_left_flag | hit;
      cur = cur | hit;
      if (last_row) mdl_count += flag;
      else mdl_pending[c-1] = flag;
    end
    // close the pixel above, whose down neighbor is this one
    if (r > 0) begin
      hit = differs(px, mdl_row_above[c]);
      if (mdl_pending[c] | hit) mdl_count++;
      cur = cur | hit;
    end
    mdl_row_above[c] = px;
    if (row_end) begin
      if (last_row) begin
        if (cur) mdl_count++;
      end else begin
        mdl_pending[c] = cur;
      end
      mdl_left_pix = '0;
      mdl_left_flag = 1'b0;
      mdl_col = 0;
      if (last_row) begin
        exp_counts.push_back(count_t'(mdl_count));
        mdl_count = 0;
        mdl_row = 0;
      end else begin
        mdl_row = r + 1;
      end
    end else begin
      mdl_left_pix = px;
      mdl_left_flag = cur;
      mdl_col = c + 1;
    end
  endtask

  // Sample both channels: check finished counts, predict on accepted pixels
  always @(posedge clk) begin
    pix_fire <= rst_n && pix_ch.valid && pix_ch.ready;
    if (rst_n) begin
      if (cnt_ch.valid && cnt_ch.ready) begin
        if (exp_counts.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("count without a finished frame: got %0d", cnt_ch.contrast_count);
          fail_count++;
        end else if (cnt_ch.contrast_count !== exp_counts[0]) begin
          if (fail_count < REPORT_LIMIT)
            $display("contrast_count mismatch: expected %0d, got %0d",
                     exp_counts[0], cnt_ch.contrast_count);
          fail_count++;
          void'(exp_counts.pop_front());
        end else begin
          void'(exp_counts.pop_front());
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        predict_pixel(pix_ch.pixel_value);
        pixels_accepted++;
      end
    end
  end

  // Offer pending pixels; hold an item until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_fire) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_value <= pixel_queue.pop_front();
      end else begin
        pix_ch.valid <= 1'b0;
        pix_ch.pixel_value <= pixel_t'($urandom);
      end
    end
  end

  // Stall the count channel at random, and fully during a hold
  always @(negedge clk) begin
    if (!rst_n) begin
      cnt_ch.ready <= 1'b0;
    end else begin
      cnt_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold so that the block backs up into its input
  initial begin : receiver_hold
    recv_hold = 1'b0;
    wait (hold_armed);
    @(negedge clk);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    recv_hold <= 1'b0;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic push_pixel(input pixel_t px);
    pixel_queue.push_back(px);
    pixels_queued++;
  endtask

  // Wait until every pixel is taken and every count has come out
  task automatic wait_idle();
    while (pixels_accepted != pixels_queued || exp_counts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_THRESHOLD: mdl_threshold = thr_t'(data);
      CFG_WIDTH:     mdl_width = fwidth_t'(data);
      CFG_HEIGHT:    mdl_height = fheight_t'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Load threshold and sizes between frames
  task automatic setup(input thr_t thr, input logic [CFG_DATA_W-1:0] w,
                       input logic [CFG_DATA_W-1:0] h);
    wait_idle();
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // Queue one whole frame at the sizes in use
  task automatic queue_frame(input fill_t fill);
    int unsigned n;
    int base;
    int spread;
    int v;
    n = active_width() * active_height();
    base = $urandom_range(255);
    spread = $urandom_range(40, 1);
    for (int k = 0; k < n; k++) begin
      case (fill)
        FILL_RANDOM: v = $urandom_range(255);
        FILL_SMOOTH: begin
          v = base + int'($urandom_range(2 * spread)) - spread;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
        end
        default: v = $urandom_range(1) ? 255 : 0;
      endcase
      push_pixel(pixel_t'(v));
    end
  endtask

  task automatic random_setup();
    int sel;
    thr_t thr;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    sel = $urandom_range(9);
    if (sel == 0) thr = '0;
    else if (sel == 1) thr = '1;
    else if (sel < 5) thr = thr_t'($urandom_range(40));
    else thr = thr_t'($urandom);
    sel = $urandom_range(19);
    if (sel == 0) w = '0;
    else if (sel < 3) w = CFG_DATA_W'($urandom_range(40, 13));
    else w = CFG_DATA_W'($urandom_range(12, 1));
    sel = $urandom_range(19);
    if (sel == 0) h = '0;
    else h = CFG_DATA_W'($urandom_range(8, 1));
    setup(thr, w, h);
  endtask

  // Random frames in small groups that share one setting; stop once the target is met
  task automatic run_random(input int target);
    int start;
    start = pixels_queued;
    while (pixels_queued - start < target) begin
      random_setup();
      repeat ($urandom_range(4, 1)) begin
        if (pixels_queued - start < target) queue_frame(fill_t'($urandom_range(2)));
      end
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_wdata = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_value = '0;
    cnt_ch.ready = 1'b0;
    pixels_queued = 0;
    pixels_accepted = 0;
    fail_count = 0;
    send_idle_pct = 33;
    recv_idle_pct = 85;
    mdl_threshold = THR_RESET;
    mdl_width = FW_RESET;
    mdl_height = FH_RESET;
    mdl_left_pix = '0;
    mdl_left_flag = 1'b0;
    mdl_col = 0;
    mdl_row = 0;
    mdl_count = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // single pixel frames, zero sizes act as one
    setup(thr_t'(0), 1, 1);
    push_pixel(8'd0);
    setup(thr_t'(0), 0, 0);
    push_pixel(8'd255);
    // zero threshold: any step counts
    setup(thr_t'(0), 2, 2);
    push_pixel(8'd0); push_pixel(8'd1); push_pixel(8'd0); push_pixel(8'd1);
    // full threshold: even the largest step does not count
    setup(thr_t'(255), 2, 2);
    push_pixel(8'd0); push_pixel(8'd255); push_pixel(8'd255); push_pixel(8'd0);
    // checkerboard of extremes just above threshold
    setup(thr_t'(254), 3, 3);
    for (int k = 0; k < 9; k++) push_pixel((k % 2) ? 8'd255 : 8'd0);
    // single row, horizontal tests only
    setup(thr_t'(128), 4, 1);
    push_pixel(8'd0); push_pixel(8'd200); push_pixel(8'd200); push_pixel(8'd0);
    // single column, vertical tests only
    setup(thr_t'(128), 1, 3);
    push_pixel(8'd10); push_pixel(8'd10); push_pixel(8'd200);

    run_random(PHASE_ITEMS);

    wait_idle();
    send_idle_pct <= 85;
    recv_idle_pct <= 33;
    run_random(PHASE_ITEMS);
    // tallest frame, height saturated
    setup(thr_t'($urandom_range(60)), 1, 10'h1FF);
    queue_frame(FILL_SMOOTH);

    wait_idle();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    // back up the block behind a held count channel
    setup(thr_t'($urandom_range(100)), 2, 2);
    hold_armed = 1'b1;
    repeat (20) queue_frame(FILL_RANDOM);
    run_random(PHASE_ITEMS);

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && exp_counts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
